FILE: sv/pgac_pkg.sv
// package: shared types, constants and functions for the present gcm cipher
`timescale 1ns / 1ps
`default_nettype none
package pgac_pkg;

   localparam int Rounds = 31;

   localparam logic [1:0] KIND_AD     = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] REG_KEY_UPPER = 2'd0;
   localparam logic [1:0] REG_KEY_LOWER = 2'd1;
   localparam logic [1:0] REG_NONCE     = 2'd2;
   localparam logic [1:0] REG_DECRYPT   = 2'd3;

   localparam logic [63:0] GF_FEEDBACK = 64'd15;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] block_in;
      logic [63:0] expected_tag;
      logic [31:0] nonce;
      logic        decrypt_mode;
   } cmd_type;

   function automatic logic [3:0] sbox(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         default: y = 4'h2;
      endcase
      return y;
   endfunction

   function automatic logic [63:0] round_fn(input logic [63:0] x);
      logic [63:0] s;
      logic [63:0] p;
      for (int n = 0; n < 16; n++) begin
         s[4*n +: 4] = sbox(x[4*n +: 4]);
      end
      p = '0;
      p[63] = s[63];
      for (int i = 0; i < 63; i++) begin
         p[(16 * i) % 63] = s[i];
      end
      return p;
   endfunction

endpackage
`default_nettype wire

FILE: sv/pgac_front.sv
// front part: accepts items, drops the unused kind, queues commands
`timescale 1ns / 1ps
`default_nettype none
module pgac_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_push,
   output logic                   req_full,
   input  wire  [1:0]             req_kind,
   input  wire  [63:0]            req_block_in,
   input  wire  [63:0]            req_expected_tag,
   input  wire  [31:0]            nonce,
   input  wire                    decrypt_mode,
   output logic                   cmd_valid,
   output pgac_pkg::cmd_type      cmd_data,
   input  wire                    cmd_take
);
   import pgac_pkg::*;

   cmd_type    q_ff [2];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, keep;

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign keep      = push_ok && (req_kind != KIND_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      wr_in  = keep ? wr_ff + 1'b1 : wr_ff;
      rd_in  = cmd_take ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {1'b0, keep} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (keep) begin
         q_ff[wr_ff] <= '{kind: req_kind, block_in: req_block_in,
                          expected_tag: req_expected_tag, nonce: nonce,
                          decrypt_mode: decrypt_mode};
      end
   end
endmodule
`default_nettype wire

FILE: sv/pgac_back.sv
// back part: cipher rounds, gf multiply and tag state, one command at a time
`timescale 1ns / 1ps
`default_nettype none
module pgac_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [63:0]            key_upper,
   input  wire  [15:0]            key_lower,
   input  wire                    key_written,
   input  wire                    cmd_valid,
   input  pgac_pkg::cmd_type      cmd_data,
   output logic                   cmd_take,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output logic [63:0]            rsp_block_out,
   output logic                   rsp_is_tag,
   output logic                   rsp_tag_match
);
   import pgac_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_HKEY  = 7'b0000010,
      ST_START = 7'b0000100,
      ST_ENC   = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_MUL2  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [4:0]  rnd_ff, rnd_in;
   logic [63:0] x_ff, x_in, ku_ff, ku_in;
   logic [15:0] kl_ff, kl_in;
   logic [63:0] hkey_ff, hkey_in, tag_ff, tag_in;
   logic        hready_ff, hready_in;
   logic [31:0] adn_ff, adn_in, dn_ff, dn_in;
   logic [63:0] a_ff, a_in, acc_ff, acc_in, res_ff, res_in;
   logic [5:0]  bit_ff, bit_in;
   logic        full_ff, full_in;
   logic [63:0] ob_ff, ob_in;
   logic        ot_ff, ot_in, om_ff, om_in;
   logic [63:0] nu, mix;
   logic [15:0] nl;
   logic [31:0] ctr;
   logic [63:0] lenblk;

   assign rsp_empty     = !full_ff;
   assign rsp_block_out = ob_ff;
   assign rsp_is_tag    = ot_ff;
   assign rsp_tag_match = om_ff;

   always_comb begin
      nu = {ku_ff[2:0], kl_ff, ku_ff[63:19]};
      nl = ku_ff[18:3];
      nu[63:60] = sbox(nu[63:60]);
      nl[15]  = nl[15] ^ rnd_ff[0];
      nu[3:0] = nu[3:0] ^ rnd_ff[4:1];
      ctr    = dn_ff + 32'd1;
      lenblk = {adn_ff[25:0], 6'd0, dn_ff[25:0], 6'd0};
      mix    = cmd_ff.decrypt_mode ? cmd_ff.block_in : res_ff;
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; rnd_in = rnd_ff;
      x_in = x_ff; ku_in = ku_ff; kl_in = kl_ff;
      hkey_in = hkey_ff; hready_in = hready_ff && !key_written; tag_in = tag_ff;
      adn_in = adn_ff; dn_in = dn_ff; a_in = a_ff; acc_in = acc_ff;
      res_in = res_ff; bit_in = bit_ff;
      full_in = full_ff && !rsp_pop;
      ob_in = ob_ff; ot_in = ot_ff; om_in = om_ff;
      cmd_take = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               ku_in    = key_upper;
               kl_in    = key_lower;
               rnd_in   = 5'd1;
               x_in     = '0;
               state_in = hready_in ? ST_START : ST_HKEY;
            end
         end
         ST_HKEY, ST_ENC: begin
            x_in  = round_fn(x_ff ^ ku_ff);
            ku_in = nu;
            kl_in = nl;
            rnd_in = rnd_ff + 5'd1;
            if (rnd_ff == 5'(Rounds)) begin
               if (state_ff == ST_HKEY) begin
                  hkey_in   = round_fn(x_ff ^ ku_ff) ^ nu;
                  hready_in = 1'b1;
                  state_in  = ST_START;
               end else begin
                  res_in = cmd_ff.block_in ^ round_fn(x_ff ^ ku_ff) ^ nu;
                  rnd_in = 5'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_START: begin
            acc_in = '0;
            bit_in = '0;
            ku_in  = key_upper;
            kl_in  = key_lower;
            rnd_in = 5'd1;
            case (cmd_ff.kind)
               KIND_AD: begin
                  a_in = tag_ff ^ cmd_ff.block_in;
                  adn_in = adn_ff + 32'd1;
                  state_in = ST_MUL;
               end
               KIND_DATA: begin
                  x_in = {cmd_ff.nonce, ctr};
                  state_in = ST_ENC;
               end
               default: begin
                  a_in = tag_ff ^ lenblk;
                  state_in = ST_MUL;
               end
            endcase
         end
         ST_MUL, ST_MUL2: begin
            if (cmd_ff.kind == KIND_DATA && bit_ff == 6'd0 && state_ff == ST_MUL
                && rnd_ff != 5'd0) begin
               a_in = tag_ff ^ mix;
               rnd_in = 5'd0;
            end else begin
               if (hkey_ff[bit_ff]) acc_in = acc_ff ^ a_ff;
               a_in = {a_ff[62:0], 1'b0} ^ (a_ff[63] ? GF_FEEDBACK : 64'd0);
               bit_in = bit_ff + 6'd1;
               if (bit_ff == 6'd63) begin
                  if (state_ff == ST_MUL && cmd_ff.kind == KIND_FINISH) begin
                     a_in = acc_in ^ {cmd_ff.nonce, 32'd0};
                     acc_in = '0;
                     state_in = ST_MUL2;
                  end else begin
                     tag_in = acc_in;
                     state_in = ST_OUT;
                  end
               end
            end
         end
         default: begin
            if (cmd_ff.kind == KIND_AD) begin
               state_in = ST_IDLE;
            end else if (!full_ff || rsp_pop) begin
               full_in = 1'b1;
               if (cmd_ff.kind == KIND_DATA) begin
                  ob_in = res_ff; ot_in = 1'b0; om_in = 1'b0;
                  dn_in = dn_ff + 32'd1;
               end else begin
                  ob_in = tag_ff; ot_in = 1'b1;
                  om_in = cmd_ff.decrypt_mode && (tag_ff == cmd_ff.expected_tag);
                  tag_in = '0; adn_in = '0; dn_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hready_ff <= 1'b0;
         hkey_ff   <= '0;
         tag_ff    <= '0;
         adn_ff    <= '0;
         dn_ff     <= '0;
         full_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hready_ff <= hready_in;
         hkey_ff   <= hkey_in;
         tag_ff    <= tag_in;
         adn_ff    <= adn_in;
         dn_ff     <= dn_in;
         full_ff   <= full_in;
      end
      cmd_ff <= cmd_in; rnd_ff <= rnd_in; x_ff <= x_in; ku_ff <= ku_in;
      kl_ff <= kl_in; a_ff <= a_in; acc_ff <= acc_in; res_ff <= res_in;
      bit_ff <= bit_in; ob_ff <= ob_in; ot_ff <= ot_in; om_ff <= om_in;
   end
endmodule
`default_nettype wire

FILE: sv/present_gcm_authenticated_cipher_top.sv
// top level: registers, front queue and back engine
//
// channel  direction  handshake          payload
// req      in         req_push/req_full  req_kind, req_block_in, req_expected_tag
// rsp      out        rsp_pop/rsp_empty  rsp_block_out, rsp_is_tag, rsp_tag_match
// csr      in         csr_valid/ready    csr_index, csr_data
//
// payload items run 31 cipher rounds, one per cycle, and every item runs a
// 64-step multiply, one bit per cycle; a finish item runs the multiply twice.
// the first item after reset or a key write also runs the rounds for the hash key.
// synchronous reset clears control and tag state; a two-entry queue and an
// output register let input and output stall independently.
`timescale 1ns / 1ps
`default_nettype none
module present_gcm_authenticated_cipher_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire  [1:0]  req_kind,
   input  wire  [63:0] req_block_in,
   input  wire  [63:0] req_expected_tag,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [63:0] rsp_block_out,
   output logic        rsp_is_tag,
   output logic        rsp_tag_match,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_data
);
   import pgac_pkg::*;

   logic [63:0] ku_ff;
   logic [15:0] kl_ff;
   logic [31:0] nonce_ff;
   logic        dec_ff, kw;
   logic        cmd_valid, cmd_take;
   cmd_type     cmd_data;

   assign csr_ready = 1'b1;
   assign kw = csr_valid && (csr_index == REG_KEY_UPPER || csr_index == REG_KEY_LOWER);

   always_ff @(posedge clock) begin
      if (reset) begin
         ku_ff <= '0; kl_ff <= '0; nonce_ff <= '0; dec_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_KEY_UPPER: ku_ff    <= csr_data;
            REG_KEY_LOWER: kl_ff    <= csr_data[15:0];
            REG_NONCE:     nonce_ff <= csr_data[31:0];
            default:       dec_ff   <= csr_data[0];
         endcase
      end
   end

   pgac_front u_front (
      .clock, .reset, .req_push, .req_full, .req_kind, .req_block_in,
      .req_expected_tag, .nonce(nonce_ff), .decrypt_mode(dec_ff),
      .cmd_valid, .cmd_data, .cmd_take
   );

   pgac_back u_back (
      .clock, .reset, .key_upper(ku_ff), .key_lower(kl_ff), .key_written(kw),
      .cmd_valid, .cmd_data, .cmd_take, .rsp_empty, .rsp_pop,
      .rsp_block_out, .rsp_is_tag, .rsp_tag_match
   );
endmodule
`default_nettype wire
